// ===== design/wgm_pkg.sv =====
// Package with the shared types and constants of the wildcard glob matcher.
package wgm_pkg;

   // Default pattern capacity in bytes.
   localparam int PATTERN_MAX_DEF = 64;

   // Pattern bytes with a special meaning.
   localparam logic [7:0] SYM_STAR = 8'd42;
   localparam logic [7:0] SYM_ANY  = 8'd63;

   // Kind of an input word.
   typedef enum logic [1:0] {
      MODE_CLEAR  = 2'd0,
      MODE_APPEND = 2'd1,
      MODE_TEXT   = 2'd2,
      MODE_END    = 2'd3
   } mode_type;

   // Controls broadcast from the top level to every cell.
   typedef struct packed {
      logic       clear;
      logic       rearm;
      logic       step;
      logic [7:0] symbol;
   } cell_ctrl_type;

endpackage

// ===== design/wgm_cell.sv =====
// One cell of the matcher chain: a pattern byte and the live bit of its position.
module wgm_cell
   import wgm_pkg::*;
#(
   parameter bit HEAD = 1'b0
) (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic          wr_en,
   input  logic          arm_in,
   input  logic          fwd_in,
   input  logic          skip_in,
   output logic          fwd_out,
   output logic          skip_out,
   output logic          star_new,
   output logic          hit
);

   logic [7:0] sym_ff, sym_in;
   logic       star_ff, star_in;
   logic       any_ff, any_in;
   logic       valid_ff, valid_in;
   logic       live_ff, live_in;
   logic       pre;

   // Pattern byte storage, with its class decoded once when written.
   always_comb begin
      sym_in   = wr_en ? ctrl.symbol : sym_ff;
      star_in  = wr_en ? (ctrl.symbol == SYM_STAR) : star_ff;
      any_in   = wr_en ? (ctrl.symbol == SYM_ANY) : any_ff;
      valid_in = ctrl.clear ? 1'b0 : (wr_en ? 1'b1 : valid_ff);
   end

   // Advance of the live bit: a hit from the left, a star holding itself, or
   // closure across a star on the left; a rearm loads arm_in instead.
   always_comb begin
      pre     = fwd_in || (live_ff && valid_ff && star_ff);
      live_in = live_ff;
      if (ctrl.rearm) begin
         live_in = arm_in;
      end else if (ctrl.step) begin
         live_in = pre || skip_in;
      end
   end

   // Signals handed to the right-hand neighbour and to the result logic.
   assign fwd_out  = live_ff && valid_ff && !star_ff
                     && (any_ff || (sym_ff == ctrl.symbol));
   assign skip_out = pre && valid_ff && star_ff;
   assign star_new = valid_in && star_in;
   assign hit      = live_ff && !valid_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         live_ff  <= HEAD;
      end else begin
         valid_ff <= valid_in;
         live_ff  <= live_in;
      end
   end

   // Payload.
   always_ff @(posedge clock) begin
      sym_ff  <= sym_in;
      star_ff <= star_in;
      any_ff  <= any_in;
   end

endmodule

// ===== design/wildcard_glob_matcher.sv =====
// A result word enters the output register when its end-of-text word is accepted.
// Throughput: one word per cycle, every mode, while req_ready is high; each text byte
// advances the whole row of pattern cells at once, and runs of stars are stored as one.
// Reset: empty pattern, no overflow, only position zero live, no result pending.
// Input stays ready whenever the output register is empty or being emptied.
module wildcard_glob_matcher
   import wgm_pkg::*;
#(
   parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_symbol,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_matched,
   output logic       rsp_overflow_error
);

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);

   logic [LEN_W-1:0] raw_len_ff, raw_len_in;
   logic [LEN_W-1:0] stored_len_ff, stored_len_in;
   logic             last_star_ff, last_star_in;
   logic             overflow_ff, overflow_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             matched_ff, matched_in;
   logic             ovf_err_ff, ovf_err_in;

   logic             accept;
   mode_type         mode;
   logic             is_star;
   logic             append_ok;
   logic             do_store;
   cell_ctrl_type    ctrl;

   logic [PATTERN_MAX:0] fwd;
   logic [PATTERN_MAX:0] skip;
   logic [PATTERN_MAX:0] star_new;
   logic [PATTERN_MAX:0] hit;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign mode      = mode_type'(req_mode);
   assign is_star   = (req_symbol == SYM_STAR);

   // An append within capacity; a star after a star is counted but not stored.
   assign append_ok = accept && (mode == MODE_APPEND) && (raw_len_ff != LEN_W'(PATTERN_MAX));
   assign do_store  = append_ok && !(is_star && last_star_ff);

   // Broadcast controls.
   always_comb begin
      ctrl.clear  = accept && (mode == MODE_CLEAR);
      ctrl.rearm  = accept && (mode != MODE_TEXT);
      ctrl.step   = accept && (mode == MODE_TEXT);
      ctrl.symbol = req_symbol;
   end

   // Pattern bookkeeping.
   always_comb begin
      raw_len_in    = raw_len_ff;
      stored_len_in = stored_len_ff;
      last_star_in  = last_star_ff;
      overflow_in   = overflow_ff;
      if (ctrl.clear) begin
         raw_len_in    = '0;
         stored_len_in = '0;
         last_star_in  = 1'b0;
         overflow_in   = 1'b0;
      end else if (accept && (mode == MODE_APPEND)) begin
         if (append_ok) begin
            raw_len_in   = raw_len_ff + LEN_W'(1);
            last_star_in = is_star;
            if (do_store) begin
               stored_len_in = stored_len_ff + LEN_W'(1);
            end
         end else begin
            overflow_in = 1'b1;
         end
      end
   end

   // Row of cells, one per pattern position plus the final position.
   for (genvar j = 0; j <= PATTERN_MAX; j++) begin : g_cell
      logic wr_en;
      logic arm_in;
      logic fwd_in;
      logic skip_in;

      assign wr_en = do_store && (stored_len_ff == LEN_W'(j));

      if (j == 0) begin : g_head
         assign arm_in  = 1'b1;
         assign fwd_in  = 1'b0;
         assign skip_in = 1'b0;
      end else begin : g_body
         assign arm_in  = (j == 1) ? star_new[0] : 1'b0;
         assign fwd_in  = fwd[j-1];
         assign skip_in = skip[j-1];
      end

      wgm_cell #(
         .HEAD (j == 0)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .wr_en    (wr_en),
         .arm_in   (arm_in),
         .fwd_in   (fwd_in),
         .skip_in  (skip_in),
         .fwd_out  (fwd[j]),
         .skip_out (skip[j]),
         .star_new (star_new[j]),
         .hit      (hit[j])
      );
   end

   // Result word register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      matched_in   = matched_ff;
      ovf_err_in   = ovf_err_ff;
      if (accept && (mode == MODE_END)) begin
         rsp_valid_in = 1'b1;
         matched_in   = !overflow_ff && (|hit);
         ovf_err_in   = overflow_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_matched        = matched_ff;
   assign rsp_overflow_error = ovf_err_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_len_ff    <= '0;
         stored_len_ff <= '0;
         last_star_ff  <= 1'b0;
         overflow_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         raw_len_ff    <= raw_len_in;
         stored_len_ff <= stored_len_in;
         last_star_ff  <= last_star_in;
         overflow_ff   <= overflow_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      matched_ff <= matched_in;
      ovf_err_ff <= ovf_err_in;
   end

endmodule

// ===== test/wildcard_glob_matcher_checker.sv =====
// Checker for the wildcard glob matcher: predicts each result word and compares it with the block's.
module wildcard_glob_matcher_checker
   import wgm_pkg::*;
#(
   parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_symbol,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       rsp_matched,
   input  logic       rsp_overflow_error,
   output int         fail_count,
   output int         pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic matched;
      logic overflow_error;
   } verdict_type;

   // Predicted state of the matcher.
   logic [7:0]           pat_bytes [PATTERN_MAX];
   int                   pat_len;
   logic [PATTERN_MAX:0] live;
   logic                 ovf;

   verdict_type expected_verdicts [$];
   verdict_type want;
   int          errs = 0;

   // A live star also makes the position after it live; stars chain left to right.
   function automatic logic [PATTERN_MAX:0] close_stars(input logic [PATTERN_MAX:0] v);
      for (int i = 0; i < pat_len; i++)
         if (v[i] && pat_bytes[i] == SYM_STAR) v[i + 1] = 1'b1;
      return v;
   endfunction

   function automatic logic [PATTERN_MAX:0] armed_positions();
      logic [PATTERN_MAX:0] v;
      v    = '0;
      v[0] = 1'b1;
      return close_stars(v);
   endfunction

   // Applies one accepted input word to the predicted state.
   task automatic apply_word(input mode_type mode, input logic [7:0] sym);
      logic [PATTERN_MAX:0] nxt;
      verdict_type          v;
      case (mode)
         MODE_CLEAR: begin
            pat_len = 0;
            ovf     = 1'b0;
            live    = armed_positions();
         end
         MODE_APPEND: begin
            if (pat_len < PATTERN_MAX) begin
               pat_bytes[pat_len] = sym;
               pat_len++;
            end else begin
               ovf = 1'b1;
            end
            live = armed_positions();
         end
         MODE_TEXT: begin
            nxt = '0;
            for (int i = 0; i < pat_len; i++) begin
               if (live[i]) begin
                  if (pat_bytes[i] == SYM_STAR) nxt[i] = 1'b1;
                  else if (pat_bytes[i] == SYM_ANY || pat_bytes[i] == sym)
                     nxt[i + 1] = 1'b1;
               end
            end
            live = close_stars(nxt);
         end
         MODE_END: begin
            v.matched        = !ovf && live[pat_len];
            v.overflow_error = ovf;
            expected_verdicts.insert(expected_verdicts.size(), v);
            live = armed_positions();
         end
         default: ;
      endcase
   endtask

   // Results are taken before requests, so a result word can never pair with
   // an end-of-text word accepted at the same edge.
   always @(posedge clock) begin
      if (reset) begin
         pat_len = 0;
         ovf     = 1'b0;
         live    = armed_positions();
         expected_verdicts.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               errs++;
               $display({"%0t: unexpected result word, expected none, ",
                         "actual matched %0b overflow_error %0b"},
                        $time, rsp_matched, rsp_overflow_error);
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_matched !== want.matched) begin
                  errs++;
                  $display("%0t: matched mismatch, expected %0b, actual %0b",
                           $time, want.matched, rsp_matched);
               end
               if (rsp_overflow_error !== want.overflow_error) begin
                  errs++;
                  $display("%0t: overflow_error mismatch, expected %0b, actual %0b",
                           $time, want.overflow_error, rsp_overflow_error);
               end
            end
         end
         if (req_valid && req_ready) apply_word(mode_type'(req_mode), req_symbol);
      end
      fail_count <= errs;
      pending    <= expected_verdicts.size();
   end

endmodule

// ===== test/wildcard_glob_matcher_test.sv =====
// Testbench top for the wildcard glob matcher: clock, reset, stimulus and verdict.
module wildcard_glob_matcher_test;
   timeunit 1ns;
   timeprecision 1ps;
   import wgm_pkg::*;

   localparam int WORD_TARGET = 925;
   localparam int CYCLE_LIMIT = 400000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic [1:0] req_mode = MODE_CLEAR;
   logic [7:0] req_symbol = 8'd0;
   logic       rsp_ready = 1'b0;
   logic       req_ready;
   logic       rsp_valid;
   logic       rsp_matched;
   logic       rsp_overflow_error;

   int         fail_count;
   int         pending;
   int         cycles = 0;
   int         words_sent = 0;
   int         stall_left = 0;
   int         stall_draw;
   logic       quiet = 1'b0;
   logic [7:0] pat_q [$];

   always #1 clock = ~clock;

   wildcard_glob_matcher DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_symbol         (req_symbol),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_matched        (rsp_matched),
      .rsp_overflow_error (rsp_overflow_error)
   );

   wildcard_glob_matcher_checker checker_i (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_symbol         (req_symbol),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_matched        (rsp_matched),
      .rsp_overflow_error (rsp_overflow_error),
      .fail_count         (fail_count),
      .pending            (pending)
   );

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Receiver stalls: mostly short, a few long, none in quiet stretches.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (quiet) begin
         rsp_ready <= 1'b1;
      end else begin
         stall_draw = $urandom_range(0, 99);
         if (stall_draw < 70) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready  <= 1'b0;
            stall_left <= (stall_draw < 95) ? $urandom_range(0, 2) : $urandom_range(5, 25);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   // Text bytes come mostly from a tiny alphabet so that literals match often.
   function automatic logic [7:0] text_byte();
      if ($urandom_range(0, 99) < 85) return 8'(8'h61 + $urandom_range(0, 2));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] pattern_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 8'(8'h61 + $urandom_range(0, 2));
      if (r < 62) return SYM_STAR;
      if (r < 82) return SYM_ANY;
      return 8'($urandom_range(0, 255));
   endfunction

   // Sends one word after a random gap and keeps a copy of the stored pattern.
   task automatic send(input mode_type mode, input logic [7:0] sym);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_mode   <= mode;
      req_symbol <= sym;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      if (mode == MODE_CLEAR) pat_q.delete();
      else if (mode == MODE_APPEND && pat_q.size() < PATTERN_MAX_DEF)
         pat_q.insert(pat_q.size(), sym);
   endtask

   // Builds a text from the current pattern, then spoils it when no match is wanted.
   task automatic send_text(input bit want_match);
      logic [7:0] txt [$];
      int         idx;
      foreach (pat_q[i]) begin
         if (pat_q[i] == SYM_STAR)
            repeat ($urandom_range(0, 3)) txt.insert(txt.size(), text_byte());
         else if (pat_q[i] == SYM_ANY) txt.insert(txt.size(), text_byte());
         else txt.insert(txt.size(), pat_q[i]);
      end
      if (!want_match) begin
         case ($urandom_range(0, 3))
            0: if (txt.size() > 0) begin
               idx      = $urandom_range(0, txt.size() - 1);
               txt[idx] = text_byte();
            end
            1: if (txt.size() > 0) txt.delete($urandom_range(0, txt.size() - 1));
            2: txt.insert($urandom_range(0, txt.size()), text_byte());
            default: begin
               txt.delete();
               repeat ($urandom_range(0, 8)) txt.insert(txt.size(), text_byte());
            end
         endcase
      end
      foreach (txt[i]) begin
         // Occasional stray word of any kind breaks the sequence.
         if ($urandom_range(0, 99) < 3)
            send(mode_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
         send(MODE_TEXT, txt[i]);
      end
      send(MODE_END, 8'($urandom_range(0, 255)));
   endtask

   initial begin
      int set_no;
      int len;
      set_no = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Empty pattern: the empty text matches, any other does not.
      send(MODE_END, 8'h00);
      send(MODE_TEXT, 8'h61);
      send(MODE_END, 8'hFF);
      // A lone star matches the empty text; star then any-byte needs at least one byte.
      send(MODE_APPEND, SYM_STAR);
      send(MODE_END, 8'h00);
      send(MODE_APPEND, SYM_ANY);
      send(MODE_TEXT, 8'hFF);
      send(MODE_END, 8'h00);
      send(MODE_TEXT, 8'h00);
      send(MODE_TEXT, 8'h01);
      send(MODE_END, 8'h00);
      // Literal extremes of the byte range.
      send(MODE_CLEAR, 8'hFF);
      send(MODE_APPEND, 8'h00);
      send(MODE_APPEND, 8'hFF);
      send(MODE_TEXT, 8'h00);
      send(MODE_TEXT, 8'hFF);
      send(MODE_END, 8'h00);
      // An append in the middle of a text restarts it.
      send(MODE_TEXT, 8'h00);
      send(MODE_APPEND, 8'h61);
      send(MODE_TEXT, 8'h00);
      send(MODE_TEXT, 8'hFF);
      send(MODE_TEXT, 8'h61);
      send(MODE_END, 8'h00);
      send(MODE_CLEAR, 8'h00);
      send(MODE_END, 8'h00);

      // Random sets: a new pattern, then a few texts against it. Every twelfth
      // pattern runs close to or past capacity; a skipped clear lets it grow on.
      while (words_sent < WORD_TARGET) begin
         quiet <= ($urandom_range(0, 99) < 15);
         if (set_no % 12 == 5) len = $urandom_range(60, 70);
         else len = $urandom_range(0, 8);
         if ($urandom_range(0, 9) != 0) send(MODE_CLEAR, 8'($urandom_range(0, 255)));
         repeat (len) send(MODE_APPEND, pattern_byte());
         repeat ($urandom_range(1, 6))
            if (words_sent < WORD_TARGET) send_text(1'($urandom_range(0, 1)));
         set_no++;
      end

      // Drain the outstanding results, then allow a few more cycles.
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
      if (fail_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
design/wgm_pkg.sv
design/wgm_cell.sv
design/wildcard_glob_matcher.sv
test/wildcard_glob_matcher_checker.sv
test/wildcard_glob_matcher_test.sv
